[sv/hvn_pkg.sv]
package hvn_pkg;

	// fixed field and datapath widths
	localparam int Y_W    = 24;
	localparam int MUL_W  = 30;
	localparam int PROD_W = 2 * MUL_W;
	localparam int MAG_W  = 42;
	localparam int SUM_W  = 63;
	localparam int ROOT_W = 31;
	localparam int Q_W    = 15;

	// fixed point constants, Q2.14
	localparam int ONE_Q14  = 16384;
	localparam int Y_OFFSET = 11469;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_ROW_LENGTH     = 3'd0,
		CFG_ROW_COUNT      = 3'd1,
		CFG_ROW_SPACING    = 3'd2,
		CFG_COLUMN_SPACING = 3'd3,
		CFG_TILT_STEP      = 3'd4
	} cfg_reg_t;

endpackage

[sv/heightfield_vertex_normals_core.sv]
// channel   | direction | handshake                 | payload
// noise     | in        | noise_valid / noise_stall | noise_height
// normal    | out       | normal_valid/normal_stall | vertex_row, vertex_column, normal_x,
//           |           |                           | normal_z, frame_done
// cfg       | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// a height of the first row yields no normal, a later height yields the normal of the vertex
// one row back; the final height of a frame also yields every normal of the last row
// the bit-pair square root (32 steps) and the two 15 step dividers are sequenced
// around one shared 30x30 multiplier and one line buffer read port
// arst_n clears the sequencer, counters, normal_valid and configuration to defaults; the
// datapath and line buffer are not cleared, and the line buffer needs no clearing pass
// a stalled result is held in the output register while the next normal is computed
module heightfield_vertex_normals_core import hvn_pkg::*; #(
	parameter int MAX_ROW_LENGTH = 63
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               noise_valid,
	output logic               noise_stall,
	input  logic [14:0]        noise_height,
	output logic               normal_valid,
	input  logic               normal_stall,
	output logic [11:0]        vertex_row,
	output logic [5:0]         vertex_column,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_z,
	output logic               frame_done,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int DEPTH = 2 * MAX_ROW_LENGTH;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_MUL   = 12'b0000_0000_0010,
		S_MWAIT = 12'b0000_0000_0100,
		S_FETCH = 12'b0000_0000_1000,
		S_FWAIT = 12'b0000_0001_0000,
		S_DIFF  = 12'b0000_0010_0000,
		S_NORM  = 12'b0000_0100_0000,
		S_ROOT  = 12'b0000_1000_0000,
		S_DINIT = 12'b0001_0000_0000,
		S_DIV   = 12'b0010_0000_0000,
		S_EMIT  = 12'b0100_0000_0000,
		S_WRITE = 12'b1000_0000_0000
	} state_t;

	typedef enum logic [2:0] {
		M_TILT = 3'd0,
		M_VX   = 3'd1,
		M_VY   = 3'd2,
		M_VZ   = 3'd3,
		M_SX   = 3'd4,
		M_SY   = 3'd5,
		M_SZ   = 3'd6
	} mul_op_t;

	state_t  state_q;
	mul_op_t mul_op_q;
	logic [1:0]  op_q;
	logic        flush_q;
	logic        last_q;
	logic        div_sel_q;
	logic [3:0]  div_cnt_q;
	logic [11:0] row_cnt_q;
	logic [5:0]  col_cnt_q;
	logic [11:0] wrow_q;
	logic [5:0]  wcol_q;

	logic [5:0]         row_length_q;
	logic [12:0]        row_count_q;
	logic [14:0]        row_spacing_q;
	logic [14:0]        column_spacing_q;
	logic signed [15:0] tilt_step_q;

	// datapath registers
	logic [14:0]           nh_q;
	logic signed [Y_W-1:0] y_q;
	logic signed [Y_W-1:0] cen_q, lft_q, top_q, bot_q;
	logic [16:0]           ab_q, cd_q;
	logic [25:0]           dxm_q, dzm_q;
	logic                  x_neg_q, z_neg_q;
	logic [MAG_W-1:0]      mx_q, my_q, mz_q;
	logic [SUM_W-1:0]      s_q, v_q, res_q, bit_q;
	logic [31:0]           rem_q;
	logic [Q_W-1:0]        nlow_q, q_q;
	logic signed [15:0]    nx_q, nz_q;

	logic [PROD_W-1:0] prod;
	logic [MUL_W-1:0]  mul_a, mul_b;
	logic signed [Y_W-1:0] rd_data;

	// effective geometry
	logic [5:0]  len_eff;
	logic [12:0] rows_eff;
	always_comb begin
		if (row_length_q < 6'd2) begin
			len_eff = 6'd2;
		end else if (row_length_q > 6'(MAX_ROW_LENGTH)) begin
			len_eff = 6'(MAX_ROW_LENGTH);
		end else begin
			len_eff = row_length_q;
		end
		if (row_count_q < 13'd2) begin
			rows_eff = 13'd2;
		end else if (row_count_q > 13'd4096) begin
			rows_eff = 13'd4096;
		end else begin
			rows_eff = row_count_q;
		end
	end

	logic col_last;
	assign col_last = (wcol_q == len_eff - 6'd1);

	// neighbour presence
	logic has_l, has_r, has_t, has_b;
	assign has_l = flush_q | (wrow_q >= 12'd2);
	assign has_r = ~flush_q;
	assign has_t = (wcol_q != 6'd0);
	assign has_b = ({1'b0, wcol_q} + 7'd1) < {1'b0, len_eff};

	// line buffer addressing: centre line and other line by row parity
	logic [AW-1:0] cur_base, prv_base, cl_base, ol_base, colx, rd_addr, wr_addr;
	logic          need;
	assign cur_base = wrow_q[0] ? AW'(MAX_ROW_LENGTH) : '0;
	assign prv_base = wrow_q[0] ? '0 : AW'(MAX_ROW_LENGTH);
	assign cl_base  = flush_q ? cur_base : prv_base;
	assign ol_base  = flush_q ? prv_base : cur_base;
	assign colx     = AW'(wcol_q);
	assign wr_addr  = cur_base + colx;

	always_comb begin
		case (op_q)
			2'd0: begin rd_addr = cl_base + colx;             need = 1'b1;  end
			2'd1: begin rd_addr = ol_base + colx;             need = has_l; end
			2'd2: begin rd_addr = cl_base + colx - AW'(1);    need = has_t; end
			2'd3: begin rd_addr = cl_base + colx + AW'(1);    need = has_b; end
			default: begin rd_addr = '0;                      need = 1'b0;  end
		endcase
	end

	hvn_line_mem #(.DEPTH(DEPTH), .AW(AW)) u_line_mem (
		.clk     (clk),
		.wr_en   (state_q == S_WRITE),
		.wr_addr (wr_addr),
		.wr_data (y_q),
		.rd_en   ((state_q == S_FETCH) && need),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// shared multiplier operand selection
	logic [15:0] tilt_mag;
	assign tilt_mag = tilt_step_q[15] ? 16'(-tilt_step_q) : 16'(tilt_step_q);

	always_comb begin
		case (mul_op_q)
			M_TILT:  begin mul_a = MUL_W'(wrow_q);   mul_b = MUL_W'(tilt_mag); end
			M_VX:    begin mul_a = MUL_W'(cd_q);     mul_b = MUL_W'(dxm_q);    end
			M_VY:    begin mul_a = MUL_W'(ab_q);     mul_b = MUL_W'(cd_q);     end
			M_VZ:    begin mul_a = MUL_W'(ab_q);     mul_b = MUL_W'(dzm_q);    end
			M_SX:    begin mul_a = mx_q[MUL_W-1:0];  mul_b = mx_q[MUL_W-1:0];  end
			M_SY:    begin mul_a = my_q[MUL_W-1:0];  mul_b = my_q[MUL_W-1:0];  end
			M_SZ:    begin mul_a = mz_q[MUL_W-1:0];  mul_b = mz_q[MUL_W-1:0];  end
			default: begin mul_a = '0;               mul_b = '0;               end
		endcase
	end

	hvn_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod)
	);

	// height of the incoming vertex, saturated to 24 bits
	logic signed [29:0] ytilt, yfull;
	logic signed [Y_W-1:0] ysat;
	always_comb begin
		ytilt = $signed({2'b0, prod[27:0]});
		if (tilt_step_q[15]) begin
			ytilt = -ytilt;
		end
		yfull = ytilt + $signed({15'b0, nh_q}) - 30'(Y_OFFSET);
		if (yfull > 30'sd8388607) begin
			ysat = 24'sh7fffff;
		end else if (yfull < -30'sd8388608) begin
			ysat = 24'sh800000;
		end else begin
			ysat = yfull[Y_W-1:0];
		end
	end

	// edge differences and step sums
	logic signed [24:0] dl, dr, dt, db;
	logic signed [25:0] dx, dz;
	logic [16:0] step_a, step_b, step_c, step_d;
	always_comb begin
		dl = has_l ? 25'(lft_q) - 25'(cen_q) : 25'sd0;
		dr = has_r ? 25'(y_q) - 25'(cen_q) : 25'sd0;
		dt = has_t ? 25'(top_q) - 25'(cen_q) : 25'sd0;
		db = has_b ? 25'(bot_q) - 25'(cen_q) : 25'sd0;
		dx = 26'(dr) - 26'(dl);
		dz = 26'(db) - 26'(dt);
		step_a = has_l ? {2'b0, row_spacing_q} : 17'(ONE_Q14);
		step_b = has_r ? {2'b0, row_spacing_q} : 17'(ONE_Q14);
		step_c = has_t ? {2'b0, column_spacing_q} : 17'(ONE_Q14);
		step_d = has_b ? {2'b0, column_spacing_q} : 17'(ONE_Q14);
	end

	// sum of squares and root step
	logic [SUM_W-1:0] s_next, trial;
	logic             big;
	assign s_next = s_q + SUM_W'(prod);
	assign trial  = res_q + bit_q;
	assign big    = |((mx_q | my_q | mz_q) >> MUL_W);

	// divider step
	logic [32:0]    dtry, rdiv;
	logic           dge;
	logic [Q_W-1:0] q_next;
	logic [29:0]    dm;
	logic [44:0]    nfull;
	assign dtry   = {rem_q, nlow_q[Q_W-1]};
	assign rdiv   = {2'b0, res_q[ROOT_W-1:0]};
	assign dge    = (dtry >= rdiv);
	assign q_next = {q_q[Q_W-2:0], dge};
	assign dm     = div_sel_q ? mz_q[MUL_W-1:0] : mx_q[MUL_W-1:0];
	assign nfull  = {1'b0, dm, 14'b0} + {15'b0, res_q[ROOT_W-1:1]};

	function automatic logic signed [15:0] signed_part(input logic [Q_W-1:0] q,
		input logic neg);
		logic [15:0] m;
		m = (q > Q_W'(ONE_Q14)) ? 16'(ONE_Q14) : {1'b0, q};
		return neg ? -$signed(m) : $signed(m);
	endfunction

	logic emit_go;
	assign emit_go = (state_q == S_EMIT) && (!normal_valid || !normal_stall);

	assign noise_stall = (state_q != S_IDLE);
	assign cfg_ready   = (state_q == S_IDLE);

	// sequencer, counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			mul_op_q         <= M_TILT;
			op_q             <= '0;
			flush_q          <= 1'b0;
			last_q           <= 1'b0;
			div_sel_q        <= 1'b0;
			div_cnt_q        <= '0;
			row_cnt_q        <= '0;
			col_cnt_q        <= '0;
			wrow_q           <= '0;
			wcol_q           <= '0;
			normal_valid     <= 1'b0;
			row_length_q     <= 6'd32;
			row_count_q      <= 13'd32;
			row_spacing_q    <= 15'd1163;
			column_spacing_q <= 15'd1163;
			tilt_step_q      <= '0;
		end else begin
			if (normal_valid && !normal_stall && !emit_go) begin
				normal_valid <= 1'b0;
			end
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ROW_LENGTH: begin
						row_length_q <= cfg_data[5:0];
						row_cnt_q    <= '0;
						col_cnt_q    <= '0;
					end
					CFG_ROW_COUNT: begin
						row_count_q <= cfg_data[12:0];
						row_cnt_q   <= '0;
						col_cnt_q   <= '0;
					end
					CFG_ROW_SPACING:    row_spacing_q    <= cfg_data[14:0];
					CFG_COLUMN_SPACING: column_spacing_q <= cfg_data[14:0];
					CFG_TILT_STEP:      tilt_step_q      <= $signed(cfg_data);
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (noise_valid) begin
						wrow_q   <= row_cnt_q;
						wcol_q   <= col_cnt_q;
						last_q   <= ({1'b0, row_cnt_q} == rows_eff - 13'd1) &&
							(col_cnt_q == len_eff - 6'd1);
						flush_q  <= 1'b0;
						mul_op_q <= M_TILT;
						state_q  <= S_MUL;
					end
				end
				S_MUL: state_q <= S_MWAIT;
				S_MWAIT: begin
					case (mul_op_q)
						M_TILT: begin
							op_q    <= '0;
							state_q <= (wrow_q != 12'd0) ? S_FETCH : S_WRITE;
						end
						M_VZ: state_q <= S_NORM;
						M_SZ: state_q <= (s_next == '0) ? S_EMIT : S_ROOT;
						default: begin
							mul_op_q <= mul_op_t'(mul_op_q + 3'd1);
							state_q  <= S_MUL;
						end
					endcase
				end
				S_FETCH: begin
					if (need) begin
						state_q <= S_FWAIT;
					end else if (op_q == 2'd3) begin
						state_q <= S_DIFF;
					end else begin
						op_q <= op_q + 2'd1;
					end
				end
				S_FWAIT: begin
					if (op_q == 2'd3) begin
						state_q <= S_DIFF;
					end else begin
						op_q    <= op_q + 2'd1;
						state_q <= S_FETCH;
					end
				end
				S_DIFF: begin
					mul_op_q <= M_VX;
					state_q  <= S_MUL;
				end
				S_NORM: begin
					if (!big) begin
						mul_op_q <= M_SX;
						state_q  <= S_MUL;
					end
				end
				S_ROOT: begin
					if (bit_q[0]) begin
						div_sel_q <= 1'b0;
						state_q   <= S_DINIT;
					end
				end
				S_DINIT: begin
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 4'd1;
					if (div_cnt_q == 4'(Q_W - 1)) begin
						if (div_sel_q) begin
							state_q <= S_EMIT;
						end else begin
							div_sel_q <= 1'b1;
							state_q   <= S_DINIT;
						end
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						normal_valid <= 1'b1;
						if (!flush_q) begin
							state_q <= S_WRITE;
						end else if (col_last) begin
							row_cnt_q <= '0;
							col_cnt_q <= '0;
							state_q   <= S_IDLE;
						end else begin
							wcol_q  <= wcol_q + 6'd1;
							op_q    <= '0;
							state_q <= S_FETCH;
						end
					end
				end
				S_WRITE: begin
					if (last_q) begin
						flush_q <= 1'b1;
						wcol_q  <= '0;
						op_q    <= '0;
						state_q <= S_FETCH;
					end else begin
						if (col_last) begin
							col_cnt_q <= '0;
							row_cnt_q <= wrow_q + 12'd1;
						end else begin
							col_cnt_q <= wcol_q + 6'd1;
							row_cnt_q <= wrow_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// arithmetic datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: nh_q <= noise_height;
			S_MWAIT: begin
				case (mul_op_q)
					M_TILT: y_q  <= ysat;
					M_VX:   mx_q <= prod[MAG_W-1:0];
					M_VY:   my_q <= prod[MAG_W-1:0];
					M_VZ:   mz_q <= prod[MAG_W-1:0];
					M_SZ: begin
						v_q   <= s_next;
						res_q <= '0;
						bit_q <= SUM_W'(1) << (SUM_W - 1);
						nx_q  <= '0;
						nz_q  <= '0;
					end
					default: s_q <= s_next;
				endcase
			end
			S_FWAIT: begin
				case (op_q)
					2'd0: cen_q <= rd_data;
					2'd1: lft_q <= rd_data;
					2'd2: top_q <= rd_data;
					default: bot_q <= rd_data;
				endcase
			end
			S_DIFF: begin
				ab_q    <= step_a + step_b;
				cd_q    <= step_c + step_d;
				dxm_q   <= dx[25] ? 26'(-dx) : 26'(dx);
				dzm_q   <= dz[25] ? 26'(-dz) : 26'(dz);
				x_neg_q <= !dx[25] && (dx != 26'sd0);
				z_neg_q <= !dz[25] && (dz != 26'sd0);
			end
			S_NORM: begin
				if (big) begin
					mx_q <= mx_q >> 1;
					my_q <= my_q >> 1;
					mz_q <= mz_q >> 1;
				end else begin
					s_q <= '0;
				end
			end
			S_ROOT: begin
				if (v_q >= trial) begin
					v_q   <= v_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_DINIT: begin
				rem_q  <= {2'b0, nfull[44:15]};
				nlow_q <= nfull[14:0];
				q_q    <= '0;
			end
			S_DIV: begin
				rem_q  <= dge ? 32'(dtry - rdiv) : dtry[31:0];
				nlow_q <= nlow_q << 1;
				q_q    <= q_next;
				if (div_cnt_q == 4'(Q_W - 1)) begin
					if (div_sel_q) begin
						nz_q <= signed_part(q_next, z_neg_q);
					end else begin
						nx_q <= signed_part(q_next, x_neg_q);
					end
				end
			end
			S_EMIT: begin
				if (emit_go) begin
					vertex_row    <= flush_q ? wrow_q : wrow_q - 12'd1;
					vertex_column <= wcol_q;
					normal_x      <= nx_q;
					normal_z      <= nz_q;
					frame_done    <= flush_q && col_last;
				end
			end
			default: ;
		endcase
	end

	// checks
	ap_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_cnt_q < len_eff)
		else $error("column counter beyond row length");

	ap_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, row_cnt_q} < rows_eff)
		else $error("row counter beyond row count");

	ap_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		normal_valid |-> (normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
			normal_z <= 16'sd16384 && normal_z >= -16'sd16384))
		else $error("normal component outside unit range");

	ap_done_at_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(normal_valid && frame_done) |-> (vertex_column == len_eff - 6'd1))
		else $error("frame end flagged before the end of the row");

endmodule

[sv/hvn_line_mem.sv]
module hvn_line_mem import hvn_pkg::*; #(
	parameter int DEPTH = 126,
	parameter int AW    = 7
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic signed [Y_W-1:0] wr_data,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output logic signed [Y_W-1:0] rd_data
);

	logic signed [Y_W-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[sv/hvn_mul.sv]
module hvn_mul import hvn_pkg::*; (
	input  logic              clk,
	input  logic [MUL_W-1:0]  op_a,
	input  logic [MUL_W-1:0]  op_b,
	output logic [PROD_W-1:0] prod_q
);

	// shared unsigned multiplier, registered product
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

[tb/sv/heightfield_vertex_normals_core_test.sv]
`timescale 1ns / 1ps

module heightfield_vertex_normals_core_test;
	import hvn_pkg::*;

	localparam int LINE_LEN = 63;
	localparam int IDLE_PCT = 37;
	localparam int RANDOM_HEIGHTS = 299;
	localparam int STEEP_HEIGHTS  = 48;
	// indexes past the last register, writes there must be dropped
	localparam logic [2:0] CFG_SPARE_LO = 3'd5;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;

	typedef struct {
		logic [11:0]        row;
		logic [5:0]         col;
		logic signed [15:0] nx;
		logic signed [15:0] nz;
		logic               done;
	} normal_t;

	// predicts the normals of the height grid and checks them in order
	class normal_scoreboard;
		normal_t     expected_q[$];
		longint      y_lines[2 * LINE_LEN];
		int unsigned next_row, next_col;
		int unsigned len_reg, rows_reg, row_sp, col_sp;
		int          tilt;
		int          errors, heights_seen, normals_seen, frames_seen;

		function new();
			len_reg  = 32;
			rows_reg = 32;
			row_sp   = 1163;
			col_sp   = 1163;
			tilt     = 0;
			next_row = 0;
			next_col = 0;
			foreach (y_lines[i]) y_lines[i] = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] d);
			case (idx)
				CFG_ROW_LENGTH: begin
					len_reg  = d[5:0];
					next_row = 0;
					next_col = 0;
				end
				CFG_ROW_COUNT: begin
					rows_reg = d[12:0];
					next_row = 0;
					next_col = 0;
				end
				CFG_ROW_SPACING:    row_sp = d[14:0];
				CFG_COLUMN_SPACING: col_sp = d[14:0];
				CFG_TILT_STEP:      tilt = $signed(d);
				default: ;
			endcase
		endfunction

		function longint unsigned floor_root(longint unsigned v);
			longint unsigned res, bit_v;
			res   = 0;
			bit_v = 64'd1 << 62;
			while (bit_v > v) bit_v >>= 2;
			while (bit_v != 0) begin
				if (v >= res + bit_v) begin
					v   -= res + bit_v;
					res = (res >> 1) + bit_v;
				end else begin
					res >>= 1;
				end
				bit_v >>= 2;
			end
			return res;
		endfunction

		function longint unsigned magnitude(longint v);
			return v < 0 ? longint'(-v) : longint'(v);
		endfunction

		function int scale_part(longint comp, int k, longint unsigned r);
			longint unsigned m;
			m = ((magnitude(comp) >> k) * ONE_Q14 + r / 2) / r;
			if (m > ONE_Q14) m = ONE_Q14;
			return comp < 0 ? -int'(m) : int'(m);
		endfunction

		// neighbours in order left, right, top, bottom
		function void make_normal(longint yc, longint nb[4], bit has[4],
				output int nx, output int nz);
			longint a, b, c, d, dl, dr, dt, db, vx, vy, vz;
			longint unsigned mx, my, mz, big, s, r;
			int k;
			a  = has[0] ? row_sp : ONE_Q14;
			b  = has[1] ? row_sp : ONE_Q14;
			c  = has[2] ? col_sp : ONE_Q14;
			d  = has[3] ? col_sp : ONE_Q14;
			dl = has[0] ? nb[0] - yc : 0;
			dr = has[1] ? nb[1] - yc : 0;
			dt = has[2] ? nb[2] - yc : 0;
			db = has[3] ? nb[3] - yc : 0;
			vx = -(c + d) * (dr - dl);
			vy = (a + b) * (c + d);
			vz = -(a + b) * (db - dt);
			mx = magnitude(vx);
			my = magnitude(vy);
			mz = magnitude(vz);
			big = mx;
			if (my > big) big = my;
			if (mz > big) big = mz;
			k = 0;
			while ((big >> k) >= (64'd1 << 30)) k++;
			mx >>= k;
			my >>= k;
			mz >>= k;
			s = mx * mx + my * my + mz * mz;
			if (s == 0) begin
				nx = 0;
				nz = 0;
				return;
			end
			r  = floor_root(s);
			nx = scale_part(vx, k, r);
			nz = scale_part(vz, k, r);
		endfunction

		function void push_normal(int unsigned row, int unsigned col, int nx, int nz, bit done);
			normal_t e;
			e.row  = row[11:0];
			e.col  = col[5:0];
			e.nx   = nx[15:0];
			e.nz   = nz[15:0];
			e.done = done;
			expected_q.push_back(e);
		endfunction

		// one accepted height transaction
		function void note_height(logic [14:0] h);
			int unsigned len, rows, r, c, cur, prv;
			longint y;
			longint nb[4];
			bit has[4];
			int nx, nz;
			len  = len_reg < 2 ? 2 : (len_reg > LINE_LEN ? LINE_LEN : len_reg);
			rows = rows_reg < 2 ? 2 : (rows_reg > 4096 ? 4096 : rows_reg);
			r = next_row;
			c = next_col;
			if (c >= len) c = 0;
			if (r >= rows) r = 0;
			heights_seen++;
			y = longint'(r) * tilt + longint'(h) - Y_OFFSET;
			if (y > 8388607) y = 8388607;
			if (y < -8388608) y = -8388608;
			cur = (r & 1) * LINE_LEN;
			prv = ((r + 1) & 1) * LINE_LEN;
			// normal of the vertex one row back
			if (r >= 1) begin
				has[0] = r >= 2;
				nb[0]  = has[0] ? y_lines[cur + c] : 0;
				has[1] = 1;
				nb[1]  = y;
				has[2] = c >= 1;
				nb[2]  = has[2] ? y_lines[prv + c - 1] : 0;
				has[3] = c + 1 < len;
				nb[3]  = has[3] ? y_lines[prv + c + 1] : 0;
				make_normal(y_lines[prv + c], nb, has, nx, nz);
				push_normal(r - 1, c, nx, nz, 0);
			end
			y_lines[cur + c] = y;
			// last height of the frame flushes the final row
			if (r == rows - 1 && c == len - 1) begin
				for (int unsigned j = 0; j < len; j++) begin
					has[0] = 1;
					nb[0]  = y_lines[prv + j];
					has[1] = 0;
					nb[1]  = 0;
					has[2] = j >= 1;
					nb[2]  = has[2] ? y_lines[cur + j - 1] : 0;
					has[3] = j + 1 < len;
					nb[3]  = has[3] ? y_lines[cur + j + 1] : 0;
					make_normal(y_lines[cur + j], nb, has, nx, nz);
					push_normal(r, j, nx, nz, j == len - 1);
				end
				frames_seen++;
				next_row = 0;
				next_col = 0;
			end else begin
				c++;
				if (c >= len) begin
					c = 0;
					r++;
				end
				next_row = r;
				next_col = c;
			end
		endfunction

		// one accepted normal transaction
		function void check_normal(normal_t got);
			normal_t e;
			normals_seen++;
			if (expected_q.size() == 0) begin
				$error("unexpected normal row %0d column %0d", got.row, got.col);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.row !== e.row) begin
				$error("vertex_row: expected %0d, got %0d", e.row, got.row);
				errors++;
			end
			if (got.col !== e.col) begin
				$error("vertex_column: expected %0d, got %0d", e.col, got.col);
				errors++;
			end
			if (got.nx !== e.nx) begin
				$error("normal_x: expected %0d, got %0d", e.nx, got.nx);
				errors++;
			end
			if (got.nz !== e.nz) begin
				$error("normal_z: expected %0d, got %0d", e.nz, got.nz);
				errors++;
			end
			if (got.done !== e.done) begin
				$error("frame_done: expected %0d, got %0d", e.done, got.done);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               noise_valid;
	logic               noise_stall;
	logic [14:0]        noise_height;
	logic               normal_valid;
	logic               normal_stall;
	logic [11:0]        vertex_row;
	logic [5:0]         vertex_column;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_z;
	logic               frame_done;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;

	normal_scoreboard grid_sb = new();
	bit send_idling;
	bit sink_idling;
	int random_heights;

	heightfield_vertex_normals_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.noise_valid  (noise_valid),
		.noise_stall  (noise_stall),
		.noise_height (noise_height),
		.normal_valid (normal_valid),
		.normal_stall (normal_stall),
		.vertex_row   (vertex_row),
		.vertex_column(vertex_column),
		.normal_x     (normal_x),
		.normal_z     (normal_z),
		.frame_done   (frame_done),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#8ms;
		$display("heightfield_vertex_normals_core_test: done, errors");
		$finish;
	end

	// random back pressure on the normal channel
	always @(negedge clk) begin
		normal_stall <= sink_idling && ($urandom_range(99) < IDLE_PCT);
	end

	// transaction monitor, results first so a same-edge input cannot be mistaken for it
	always @(posedge clk) begin
		normal_t got;
		if (arst_n) begin
			if (normal_valid && !normal_stall) begin
				got.row  = vertex_row;
				got.col  = vertex_column;
				got.nx   = normal_x;
				got.nz   = normal_z;
				got.done = frame_done;
				grid_sb.check_normal(got);
			end
			if (noise_valid && !noise_stall)
				grid_sb.note_height(noise_height);
		end
	end

	// entered and left at a falling edge
	task automatic send_height(logic [14:0] h);
		if (send_idling && $urandom_range(99) < IDLE_PCT) begin
			noise_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		noise_valid  <= 1'b1;
		noise_height <= h;
		do @(posedge clk); while (noise_stall);
		@(negedge clk);
	endtask

	// entered at a falling edge, left at a falling edge after cfg_valid drops following the write
	task automatic write_reg(logic [2:0] idx, logic [15:0] d);
		noise_valid <= 1'b0;
		cfg_valid   <= 1'b1;
		cfg_index   <= idx;
		cfg_data    <= d;
		do @(posedge clk); while (!cfg_ready);
		grid_sb.write_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// drain all normals, then cover a height still in flight with no normal due
	task automatic wait_drained();
		noise_valid <= 1'b0;
		while (grid_sb.expected_q.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	function automatic logic [14:0] pick_height();
		case ($urandom_range(9))
			0:       return 15'd0;
			1:       return 15'd16384;
			2:       return 15'($urandom_range(32767));
			default: return 15'($urandom_range(16384));
		endcase
	endfunction

	function automatic logic [15:0] pick_spacing();
		case ($urandom_range(7))
			0:       return 16'd1;
			1:       return 16'd32767;
			2:       return 16'd0;
			default: return 16'($urandom_range(200, 6000));
		endcase
	endfunction

	// one random geometry, then a random count of heights, capped by the remaining budget
	task automatic random_phase();
		int len, rows, count;
		len  = ($urandom_range(9) == 0) ? 63 : $urandom_range(2, 6);
		rows = ($urandom_range(9) == 0) ? $urandom_range(0, 8191) : $urandom_range(2, 5);
		write_reg(CFG_ROW_LENGTH, 16'(len));
		write_reg(CFG_ROW_COUNT, 16'(rows));
		write_reg(CFG_ROW_SPACING, pick_spacing());
		write_reg(CFG_COLUMN_SPACING, pick_spacing());
		write_reg(CFG_TILT_STEP, ($urandom_range(4) == 0) ? 16'($urandom) :
			16'($urandom_range(0, 3000) - 1500));
		if (len < 2) len = 2;
		if (rows < 2 || rows > 5) rows = 4;
		count = len * rows * $urandom_range(1, 2);
		if ($urandom_range(4) == 0) count = $urandom_range(1, count);
		if (count > RANDOM_HEIGHTS - random_heights) count = RANDOM_HEIGHTS - random_heights;
		send_idling = $urandom_range(3) != 0;
		sink_idling = $urandom_range(3) != 0;
		for (int i = 0; i < count; i++) send_height(pick_height());
		random_heights += count;
		wait_drained();
	endtask

	initial begin
		arst_n       = 1'b0;
		noise_valid  = 1'b0;
		noise_height = '0;
		normal_stall = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_ROW_LENGTH;
		cfg_data     = '0;
		send_idling  = 1'b0;
		sink_idling  = 1'b0;
		random_heights = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// spare indexes, then a 3x3 grid with zero spacing for the degenerate centre
		write_reg(CFG_SPARE_LO, 16'hffff);
		write_reg(CFG_SPARE_HI, 16'h0001);
		write_reg(CFG_ROW_LENGTH, 16'd3);
		write_reg(CFG_ROW_COUNT, 16'd3);
		write_reg(CFG_ROW_SPACING, 16'd0);
		write_reg(CFG_COLUMN_SPACING, 16'd0);
		write_reg(CFG_TILT_STEP, 16'h7fff);
		send_height(15'd0);
		send_height(15'd16384);
		send_height(15'h7fff);
		send_height(15'd11469);
		send_height(15'd5000);
		send_height(15'h2aaa);
		send_height(15'h5555);
		send_height(15'd1);
		send_height(15'd16383);
		wait_drained();

		// lengths below range saturate to two, huge row count to the limit
		write_reg(CFG_ROW_LENGTH, 16'd0);
		write_reg(CFG_ROW_COUNT, 16'h1fff);
		write_reg(CFG_ROW_SPACING, 16'h7fff);
		write_reg(CFG_COLUMN_SPACING, 16'd1);
		write_reg(CFG_TILT_STEP, 16'h8000);
		for (int i = 0; i < 6; i++) send_height(pick_height());
		wait_drained();
		// geometry change mid frame, then a row count of one
		write_reg(CFG_ROW_LENGTH, 16'd1);
		write_reg(CFG_ROW_COUNT, 16'd1);
		for (int i = 0; i < 8; i++) send_height(pick_height());
		wait_drained();

		// random geometries
		while (random_heights < RANDOM_HEIGHTS) random_phase();

		// steepest tilt in one direction, a long stretch with no idling
		send_idling = 1'b0;
		sink_idling = 1'b0;
		write_reg(CFG_ROW_LENGTH, 16'd2);
		write_reg(CFG_ROW_COUNT, 16'd4096);
		write_reg(CFG_ROW_SPACING, 16'd1163);
		write_reg(CFG_COLUMN_SPACING, 16'd1163);
		write_reg(CFG_TILT_STEP, ($urandom_range(1) != 0) ? 16'h8000 : 16'h7fff);
		for (int i = 0; i < STEEP_HEIGHTS; i++) send_height(pick_height());
		wait_drained();

		$display("covered %0d heights, %0d normals, %0d whole frames",
			grid_sb.heights_seen, grid_sb.normals_seen, grid_sb.frames_seen);
		$display("with saturated geometry, zero spacing, extreme tilt and mid-frame restarts");
		if (grid_sb.errors == 0 && grid_sb.expected_q.size() == 0) begin
			$display("heightfield_vertex_normals_core_test: done, clean");
		end else begin
			$display("heightfield_vertex_normals_core_test: done, errors");
		end
		$finish;
	end

endmodule
